// File: rtl/led_blink_pattern_sequencer_defines.svh
// Assertion macros shared by the LED blink pattern sequencer RTL.
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

// Check an invariant on every rising clock edge outside reset.
`define LBPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

// Check a same-cycle implication.
`define LBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check a next-cycle implication.
`define LBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/lbps_pkg.sv
// Types, pattern codes and phase-time helpers for the LED blink pattern sequencer.
package lbps_pkg;

    localparam int unsigned RATE_W    = 10;
    localparam int unsigned TICKS_W   = 11;
    localparam int unsigned PAT_W     = 4;
    localparam int unsigned LOOPS_W   = 8;
    localparam int unsigned PULSE_W   = 3;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned LEVELS_W  = 4;

    localparam logic [RATE_W-1:0] RATE_RESET = 10'd10;

    localparam logic [PAT_W-1:0] PAT_NONE        = 4'd0;
    localparam logic [PAT_W-1:0] PAT_ON          = 4'd1;
    localparam logic [PAT_W-1:0] PAT_OFF         = 4'd2;
    localparam logic [PAT_W-1:0] PAT_FAST        = 4'd3;
    localparam logic [PAT_W-1:0] PAT_SLOW        = 4'd4;
    localparam logic [PAT_W-1:0] PAT_GROUP_FIRST = 4'd5;
    localparam logic [PAT_W-1:0] PAT_GROUP_LAST  = 4'd9;
    localparam logic [PAT_W-1:0] GROUP_PULSE_OFS = 4'd3;

    // Phase lengths in units of 100 ms.
    localparam logic [4:0] K_100  = 5'd1;
    localparam logic [4:0] K_200  = 5'd2;
    localparam logic [4:0] K_400  = 5'd4;
    localparam logic [4:0] K_500  = 5'd5;
    localparam logic [4:0] K_1600 = 5'd16;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SH for x below 2**14.
    localparam logic [29:0] RECIP10    = 30'd52429;
    localparam int unsigned RECIP10_SH = 19;

    typedef struct packed {
        logic [TICKS_W-1:0] t100;
        logic [TICKS_W-1:0] t200;
        logic [TICKS_W-1:0] t400;
        logic [TICKS_W-1:0] t500;
        logic [TICKS_W-1:0] t1600;
    } t_phase_ticks;

    typedef struct packed {
        logic               tick;
        logic               set;
        logic [PAT_W-1:0]   pattern;
        logic [LOOPS_W-1:0] loop_count;
    } t_led_cmd;

    // Ticks for k*100 ms at the given tick rate, at least one tick.
    function automatic logic [TICKS_W-1:0] phase_ticks(
        input logic [RATE_W-1:0] rate,
        input logic [4:0]        k
    );
        logic [13:0]        x;
        logic [29:0]        p;
        logic [TICKS_W-1:0] q;
        x = 14'({4'd0, rate} * {9'd0, k});
        p = {16'd0, x} * RECIP10;
        q = p[RECIP10_SH +: TICKS_W];
        if (q == '0) begin
            q = TICKS_W'(1);
        end
        return q;
    endfunction

    function automatic t_phase_ticks all_phase_ticks(input logic [RATE_W-1:0] rate);
        t_phase_ticks t;
        t.t100  = phase_ticks(rate, K_100);
        t.t200  = phase_ticks(rate, K_200);
        t.t400  = phase_ticks(rate, K_400);
        t.t500  = phase_ticks(rate, K_500);
        t.t1600 = phase_ticks(rate, K_1600);
        return t;
    endfunction

    function automatic logic is_group(input logic [PAT_W-1:0] p);
        return (p >= PAT_GROUP_FIRST) && (p <= PAT_GROUP_LAST);
    endfunction

    function automatic logic pattern_valid(input logic [PAT_W-1:0] p);
        return (p != PAT_NONE) && (p <= PAT_GROUP_LAST);
    endfunction

endpackage

// File: rtl/lbps_phase_timer.sv
// Tick-rate register and the phase lengths in ticks derived from it.
module lbps_phase_timer
    import lbps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [RATE_W-1:0]   i_cfg_data,
    output t_phase_ticks        o_ticks
);

    t_phase_ticks r_ticks;
    t_phase_ticks n_ticks;

    always_comb begin
        n_ticks = all_phase_ticks(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= all_phase_ticks(RATE_RESET);
        end else if (i_cfg_valid) begin
            r_ticks <= n_ticks;
        end
    end

    assign o_ticks = r_ticks;

endmodule

// File: rtl/lbps_led_channel.sv
// Per-LED pattern state and phase countdown.
`include "led_blink_pattern_sequencer_defines.svh"

module lbps_led_channel
    import lbps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_led_cmd     i_cmd,
    input  t_phase_ticks i_ticks,
    output logic         o_lit_next
);

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [PULSE_W-1:0] pulse;
        logic [LOOPS_W-1:0] loops;
        logic [TICKS_W-1:0] ticks;
        logic               running;
        logic               lit;
    } t_led_state;

    t_led_state r_st;
    t_led_state n_st;

    function automatic t_led_state arm(input t_led_state s, input logic [TICKS_W-1:0] t);
        t_led_state o;
        o         = s;
        o.running = 1'b1;
        o.ticks   = t;
        return o;
    endfunction

    function automatic t_led_state halt(input t_led_state s);
        t_led_state o;
        o         = s;
        o.running = 1'b0;
        o.ticks   = '0;
        return o;
    endfunction

    function automatic t_led_state on_phase(input t_led_state s, input t_phase_ticks t);
        t_led_state o;
        o     = s;
        o.lit = 1'b1;
        if (s.pattern == PAT_OFF) begin
            o.lit = 1'b0;
            o     = halt(o);
        end else if (s.pattern == PAT_SLOW) begin
            o = arm(o, t.t500);
        end else if (s.pattern == PAT_FAST || is_group(s.pattern)) begin
            o = arm(o, t.t100);
        end else begin
            o = halt(o);
        end
        return o;
    endfunction

    function automatic t_led_state off_phase(input t_led_state s, input t_phase_ticks t);
        t_led_state       o;
        logic             last_loop;
        logic [PAT_W-1:0] pulses;
        o         = s;
        o.lit     = 1'b0;
        last_loop = (s.loops == LOOPS_W'(1));
        pulses    = s.pattern - GROUP_PULSE_OFS;
        if (s.loops != '0) begin
            o.loops = s.loops - LOOPS_W'(1);
        end
        if (s.pattern == PAT_ON) begin
            o.loops = s.loops;
            o.lit   = 1'b1;
            o       = halt(o);
        end else if (s.pattern == PAT_FAST || s.pattern == PAT_SLOW) begin
            if (last_loop) begin
                o = halt(o);
            end else begin
                o = arm(o, (s.pattern == PAT_FAST) ? t.t200 : t.t500);
            end
        end else if (is_group(s.pattern)) begin
            if ({1'b0, s.pulse} < pulses) begin
                o.loops = s.loops;
                o.pulse = s.pulse + PULSE_W'(1);
                o       = arm(o, t.t400);
            end else begin
                o.pulse = PULSE_W'(1);
                if (last_loop) begin
                    o = halt(o);
                end else begin
                    o = arm(o, t.t1600);
                end
            end
        end else begin
            o.loops = s.loops;
            o       = halt(o);
        end
        return o;
    endfunction

    always_comb begin
        n_st = r_st;
        if (i_cmd.set) begin
            n_st.pattern = i_cmd.pattern;
            n_st.pulse   = PULSE_W'(1);
            n_st.loops   = i_cmd.loop_count;
            if (!r_st.running) begin
                n_st = on_phase(n_st, i_ticks);
            end
        end else if (i_cmd.tick && r_st.running) begin
            if (r_st.ticks > TICKS_W'(1)) begin
                n_st.ticks = r_st.ticks - TICKS_W'(1);
            end else if (r_st.lit) begin
                n_st = off_phase(r_st, i_ticks);
            end else begin
                n_st = on_phase(r_st, i_ticks);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.pattern <= PAT_NONE;
            r_st.pulse   <= PULSE_W'(1);
            r_st.loops   <= '0;
            r_st.ticks   <= '0;
            r_st.running <= 1'b0;
            r_st.lit     <= 1'b0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_lit_next = n_st.lit;

    `LBPS_ASSERT_ALWAYS(a_run_has_ticks, i_clk, i_rst_n, r_st.running == (r_st.ticks != '0))
    `LBPS_ASSERT_ALWAYS(a_pulse_nonzero, i_clk, i_rst_n, r_st.pulse != '0)
    `LBPS_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !r_st.running && !i_cmd.set, $stable(r_st))

endmodule

// File: rtl/led_blink_pattern_sequencer.sv
// Top level of the LED blink pattern sequencer: command decode, LED bank, result register.
//
// Every transaction on the slave stream is either a tick (tuser 0), which advances all
// running LEDs by one countdown step, or a set (tuser 1), which loads one LED's pattern
// and loop count. Each transaction yields exactly one result: the LED levels after it,
// presented on the master stream in the cycle after acceptance. One transaction is taken
// per cycle; the only limit is the single result register, which holds while the master
// side stalls. Phase lengths are recomputed from tick_rate_hz at the cfg write and are
// valid for the next transaction. LEDs beyond index 3 exist but are not addressable or
// visible.
`include "led_blink_pattern_sequencer_defines.svh"

module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int unsigned LED_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RATE_W-1:0]   i_cfg_data,     // tick_rate_hz
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,        // led_index[1:0], pattern[5:2], loop_count[13:6]
    input  logic                s_tuser,        // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata         // led_levels[3:0]
);

    logic               accept;
    logic [IDX_W-1:0]   in_idx;
    logic [PAT_W-1:0]   in_pat;
    logic [LOOPS_W-1:0] in_loops;
    logic               set_ok;
    t_phase_ticks       phase_ticks_w;
    logic [LED_COUNT-1:0] lit_next;
    logic [LEVELS_W-1:0]  n_levels;
    logic [LEVELS_W-1:0]  r_levels;
    logic                 r_m_valid;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_m_valid || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign in_idx      = s_tdata[1:0];
    assign in_pat      = s_tdata[5:2];
    assign in_loops    = s_tdata[13:6];
    assign set_ok      = accept && s_tuser && pattern_valid(in_pat);

    lbps_phase_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_ticks     (phase_ticks_w)
    );

    for (genvar gi = 0; gi < LED_COUNT; gi++) begin : g_led
        t_led_cmd cmd;
        always_comb begin
            cmd.tick       = accept && !s_tuser;
            cmd.pattern    = in_pat;
            cmd.loop_count = in_loops;
            if (gi < (1 << IDX_W)) begin
                cmd.set = set_ok && (in_idx == IDX_W'(gi));
            end else begin
                cmd.set = 1'b0;
            end
        end

        lbps_led_channel u_led (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_ticks    (phase_ticks_w),
            .o_lit_next (lit_next[gi])
        );
    end

    for (genvar gj = 0; gj < LEVELS_W; gj++) begin : g_lvl
        if (gj < LED_COUNT) begin : g_on
            assign n_levels[gj] = lit_next[gj];
        end else begin : g_off
            assign n_levels[gj] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_levels <= n_levels;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(8 - LEVELS_W){1'b0}}, r_levels};

    `LBPS_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, r_m_valid)
    `LBPS_ASSERT_IMP(a_no_accept_when_full, i_clk, i_rst_n, r_m_valid && !m_tready, !accept)
    `LBPS_ASSERT_NEXT(a_idle_levels_hold, i_clk, i_rst_n, !accept, $stable(r_levels))

endmodule

// File: test/lbps_tb_pkg.sv
// Stream item kinds and the LED bank size shared by the LED blink pattern sequencer testbench modules.
package lbps_tb_pkg;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    localparam int unsigned BANK_SIZE = 4;

endpackage

// File: test/led_blink_pattern_sequencer_checker.sv
// Stream monitor that predicts the LED levels after every transaction and compares them.
module led_blink_pattern_sequencer_checker
    import lbps_pkg::*;
    import lbps_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [RATE_W-1:0]  rate_hz;
    logic [PAT_W-1:0]   pat_q   [BANK_SIZE];
    logic [PULSE_W-1:0] pulse_q [BANK_SIZE];
    logic [LOOPS_W-1:0] loops_q [BANK_SIZE];
    logic [TICKS_W-1:0] ticks_q [BANK_SIZE];
    bit                 run_q   [BANK_SIZE];
    bit                 lit_q   [BANK_SIZE];
    logic [3:0]         levels_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [TICKS_W-1:0] ms_to_ticks(int unsigned ms);
        int unsigned t;
        t = ms * rate_hz / 1000;
        if (t == 0) begin
            t = 1;
        end
        return t[TICKS_W-1:0];
    endfunction

    function automatic void load_countdown(int i, int unsigned ms);
        run_q[i]   = 1'b1;
        ticks_q[i] = ms_to_ticks(ms);
    endfunction

    function automatic void halt_led(int i);
        run_q[i]   = 1'b0;
        ticks_q[i] = '0;
    endfunction

    function automatic bit last_loop(int i);
        if (loops_q[i] != 0) begin
            loops_q[i]--;
            return loops_q[i] == 0;
        end
        return 1'b0;
    endfunction

    function automatic bit group_pat(logic [PAT_W-1:0] p);
        return p >= PAT_GROUP_FIRST && p <= PAT_GROUP_LAST;
    endfunction

    function automatic void light_led(int i);
        logic [PAT_W-1:0] p;
        p = pat_q[i];
        lit_q[i] = 1'b1;
        if (p == PAT_OFF) begin
            lit_q[i] = 1'b0;
            halt_led(i);
        end else if (p == PAT_SLOW) begin
            load_countdown(i, 500);
        end else if (p == PAT_FAST || group_pat(p)) begin
            load_countdown(i, 100);
        end else begin
            halt_led(i);
        end
    endfunction

    function automatic void darken_led(int i);
        logic [PAT_W-1:0] p;
        logic [PAT_W-1:0] pulses;
        p = pat_q[i];
        lit_q[i] = 1'b0;
        if (p == PAT_ON) begin
            lit_q[i] = 1'b1;
            halt_led(i);
        end else if (p == PAT_FAST || p == PAT_SLOW) begin
            if (last_loop(i)) begin
                halt_led(i);
            end else begin
                load_countdown(i, (p == PAT_FAST) ? 200 : 500);
            end
        end else if (group_pat(p)) begin
            pulses = p - GROUP_PULSE_OFS;
            if ({1'b0, pulse_q[i]} < pulses) begin
                pulse_q[i]++;
                load_countdown(i, 400);
            end else begin
                pulse_q[i] = PULSE_W'(1);
                if (last_loop(i)) begin
                    halt_led(i);
                end else begin
                    load_countdown(i, 1600);
                end
            end
        end else begin
            halt_led(i);
        end
    endfunction

    function automatic void reset_bank();
        rate_hz = RATE_RESET;
        for (int i = 0; i < BANK_SIZE; i++) begin
            pat_q[i]   = PAT_NONE;
            pulse_q[i] = PULSE_W'(1);
            loops_q[i] = '0;
            ticks_q[i] = '0;
            run_q[i]   = 1'b0;
            lit_q[i]   = 1'b0;
        end
    endfunction

    function automatic logic [3:0] step_bank(logic mode, logic [IDX_W-1:0] idx,
                                             logic [PAT_W-1:0] pat, logic [LOOPS_W-1:0] cnt);
        logic [3:0] levels;
        if (mode == MODE_SET) begin
            if (pat != PAT_NONE && pat <= PAT_GROUP_LAST) begin
                pat_q[idx]   = pat;
                pulse_q[idx] = PULSE_W'(1);
                loops_q[idx] = cnt;
                if (!run_q[idx]) begin
                    light_led(idx);
                end
            end
        end else begin
            for (int i = 0; i < BANK_SIZE; i++) begin
                if (run_q[i]) begin
                    if (ticks_q[i] > 1) begin
                        ticks_q[i]--;
                    end else if (lit_q[i]) begin
                        darken_led(i);
                    end else begin
                        light_led(i);
                    end
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            levels[i] = lit_q[i];
        end
        return levels;
    endfunction

    always @(posedge i_clk) begin
        logic [3:0] want;
        if (!i_rst_n) begin
            reset_bank();
            levels_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rate_hz = i_cfg_data;
            end
            if (s_tvalid && s_tready) begin
                levels_due.push_back(step_bank(s_tuser, s_tdata[1:0], s_tdata[5:2],
                                               s_tdata[13:6]));
            end
            if (m_tvalid && m_tready) begin
                if (levels_due.size() == 0) begin
                    o_errors++;
                    $display("%0t ns: led_levels expected none, got %b", $time, m_tdata[3:0]);
                end else begin
                    want = levels_due.pop_front();
                    if (m_tdata[3:0] !== want) begin
                        o_errors++;
                        $display("%0t ns: led_levels expected %b, got %b",
                                 $time, want, m_tdata[3:0]);
                    end
                end
            end
        end
        o_pending = levels_due.size();
    end

endmodule

// File: test/led_blink_pattern_sequencer_test.sv
// Top of the LED blink pattern sequencer testbench: clock, reset, stimulus and verdict.
module led_blink_pattern_sequencer_test
    import lbps_pkg::*;
    import lbps_tb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data  = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    int          chk_errors;
    int          chk_pending;
    bit          calm        = 1'b0;
    int          stall_left  = 0;

    always #6 i_clk = ~i_clk;

    led_blink_pattern_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    led_blink_pattern_sequencer_checker u_levels_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // stall the result side at random
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic mode, logic [IDX_W-1:0] idx, logic [PAT_W-1:0] pat,
                             logic [LOOPS_W-1:0] cnt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, cnt, pat, idx};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, IDX_W'($urandom_range(0, 3)), PAT_W'($urandom_range(0, 15)),
                  LOOPS_W'($urandom_range(0, 255)));
    endtask

    // hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [9:0] rate);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [9:0]         rates [7];
        logic               mode;
        logic [IDX_W-1:0]   idx;
        logic [PAT_W-1:0]   pat;
        logic [LOOPS_W-1:0] cnt;
        int                 n;
        rates = '{10'd0, 10'd1, 10'd1000, 10'd1023, 10'd0, 10'd0, 10'd0};
        rates[4] = 10'($urandom_range(2, 30));
        rates[5] = 10'($urandom_range(1, 1000));
        rates[6] = 10'($urandom_range(2, 30));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset tick rate
        send_item(MODE_SET, 2'd0, PAT_ON, 8'd0);
        send_item(MODE_SET, 2'd1, PAT_OFF, 8'd0);
        send_item(MODE_SET, 2'd2, PAT_FAST, 8'd1);
        send_item(MODE_SET, 2'd3, PAT_GROUP_LAST, 8'hFF);
        repeat (3) send_tick();
        send_item(MODE_SET, 2'd0, PAT_NONE, 8'hFF);
        send_item(MODE_SET, 2'd1, 4'hF, 8'hAA);
        send_item(MODE_SET, 2'd3, PAT_SLOW, 8'd2);
        send_item(MODE_SET, 2'd1, PAT_GROUP_FIRST, 8'd1);
        send_item(MODE_SET, 2'd0, PAT_GROUP_FIRST + 4'd1, 8'd0);
        send_item(MODE_SET, 2'd2, PAT_GROUP_FIRST + 4'd2, 8'd3);
        send_item(MODE_SET, 2'd3, PAT_GROUP_FIRST + 4'd3, 8'd1);
        repeat (10) send_tick();

        foreach (rates[ph]) begin
            drain();
            write_rate(rates[ph]);
            n = 0;
            while (n < 100) begin
                if (n % 40 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                mode = ($urandom_range(0, 99) < 70) ? MODE_TICK : MODE_SET;
                idx  = IDX_W'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 85) begin
                    pat = PAT_W'($urandom_range(1, 9));
                end else if ($urandom_range(0, 1) == 0) begin
                    pat = PAT_NONE;
                end else begin
                    pat = PAT_W'($urandom_range(10, 15));
                end
                cnt = LOOPS_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 255));
                send_item(mode, idx, pat, cnt);
                if (mode == MODE_TICK || (pat != PAT_NONE && pat <= PAT_GROUP_LAST)) begin
                    n++;
                end
            end
        end

        drain();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
